@@ rtl/sorted_priority_table_with_cursor_macros.svh @@
// assertion macros shared by the table logic
`ifndef SORTED_PRIORITY_TABLE_WITH_CURSOR_MACROS_SVH
`define SORTED_PRIORITY_TABLE_WITH_CURSOR_MACROS_SVH

// condition must hold in the same cycle
`define SPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the next cycle
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/spt_pkg.sv @@
package spt_pkg;

    localparam int IdW  = 16;
    localparam int KeyW = 17;
    localparam int OpW  = 3;
    localparam int StW  = 2;
    localparam int InW  = 40;

    typedef enum logic [OpW-1:0] {
        OP_INSERT     = 3'd0,
        OP_REMOVE_ID  = 3'd1,
        OP_REMOVE_LOW = 3'd2,
        OP_NEXT       = 3'd3,
        OP_PREV       = 3'd4,
        OP_CURRENT    = 3'd5,
        OP_RESET_CUR  = 3'd6,
        OP_EXISTS     = 3'd7
    } t_op;

    typedef enum logic [StW-1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2,
        ST_END  = 2'd3
    } t_status;

    typedef struct packed {
        logic [IdW-1:0]  id;
        logic [KeyW-1:0] key;
    } t_entry;

    typedef enum logic [1:0] {
        LD_HOLD  = 2'd0,
        LD_LEFT  = 2'd1,
        LD_RIGHT = 2'd2,
        LD_NEW   = 2'd3
    } t_load;

    typedef struct packed {
        t_load load;
        logic  mk;
    } t_cell_ctl;

    typedef struct packed {
        logic ge;
        logic eq;
        logic idm;
    } t_cell_flags;

endpackage

@@ rtl/spt_cell.sv @@
module spt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spt_pkg::t_cell_ctl  i_ctl,
    input  spt_pkg::t_entry     i_new,
    input  spt_pkg::t_entry     i_left,
    input  spt_pkg::t_entry     i_right,
    output spt_pkg::t_entry     o_entry,
    output logic                o_mk,
    output spt_pkg::t_cell_flags o_flags
);

    spt_pkg::t_entry r_entry;
    logic            r_mk;

    always_ff @(posedge i_clk) begin
        case (i_ctl.load)
            spt_pkg::LD_LEFT:  r_entry <= i_left;
            spt_pkg::LD_RIGHT: r_entry <= i_right;
            spt_pkg::LD_NEW:   r_entry <= i_new;
            default:           r_entry <= r_entry;
        endcase
    end

    // cursor marker travels with its entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mk <= 1'b0;
        end else begin
            r_mk <= i_ctl.mk;
        end
    end

    assign o_entry     = r_entry;
    assign o_mk        = r_mk;
    assign o_flags.ge  = (i_new.key >= r_entry.key);
    assign o_flags.eq  = (i_new.key == r_entry.key);
    assign o_flags.idm = (i_new.id == r_entry.id);

endmodule

@@ rtl/sorted_priority_table_with_cursor.sv @@
// an accepted input passes the compare/shift state (S_EXEC), then the report state (S_EMIT), before its result is valid
// a new input is taken only while idle or while the report state passes its result on, one input at a time
// every cell compares against the broadcast id and key; on insert or remove, cells past that point shift one place
// reset: synchronous active low; table empty, no cursor, no result pending
// entry contents are not reset and are only read below the fill count
module sorted_priority_table_with_cursor #(
    parameter int CAPACITY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // opcode[2:0], entry_id[18:3], priority_key[35:19], zero pad
    input  logic [spt_pkg::InW-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status, result_id, result_key, entry_count, found, zero pad
    output logic [((spt_pkg::StW + spt_pkg::IdW + spt_pkg::KeyW + $clog2(CAPACITY + 1) + 1)
                   + 7) / 8 * 8 - 1:0] m_axis_tdata
);

    localparam int N     = CAPACITY;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int OutFw = spt_pkg::StW + spt_pkg::IdW + spt_pkg::KeyW + CW + 1;
    localparam int OutW  = (OutFw + 7) / 8 * 8;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    spt_pkg::t_op       r_op;
    spt_pkg::t_entry    r_new;
    logic [CW-1:0]      r_count, n_count;
    spt_pkg::t_status   r_status, n_status;
    logic               r_found, n_found;
    logic               r_use_cur, n_use_cur;
    spt_pkg::t_entry    r_rentry, n_rentry;
    logic               r_out_valid;
    logic [OutW-1:0]    r_out_data, n_out_data;

    logic in_accept, out_free;

    spt_pkg::t_entry      w_entry [N];
    spt_pkg::t_cell_flags w_flags [N];
    spt_pkg::t_cell_ctl   w_ctl   [N];

    logic [N-1:0] w_mk, w_occ, w_ge, w_eq, w_idm;
    logic [N-1:0] w_mk_pv, w_mk_nx, w_occ_nx, w_occ_nx2, w_occ_pv;
    logic [N-1:0] w_is_last, w_s, w_s_pv, w_t, w_first_free;
    logic [N-1:0] w_seen, w_first_m, w_pick, w_pick_nx, w_rm_after;

    logic w_empty, w_full, w_exc, w_eq_last, w_any_match;
    logic w_cv, w_mk_rem, w_end_next, w_end_prev, w_ins_ok, w_rm_ok;
    spt_pkg::t_entry w_pick_entry, w_cur_entry;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) || ((r_state == S_EMIT) && out_free);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            spt_pkg::t_entry w_left, w_right;

            if (gi == 0) begin : g_l0
                assign w_left = r_new;
            end else begin : g_ln
                assign w_left = w_entry[gi-1];
            end
            if (gi == N - 1) begin : g_rl
                assign w_right = w_entry[gi];
            end else begin : g_rn
                assign w_right = w_entry[gi+1];
            end

            spt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[gi]),
                .i_new   (r_new),
                .i_left  (w_left),
                .i_right (w_right),
                .o_entry (w_entry[gi]),
                .o_mk    (w_mk[gi]),
                .o_flags (w_flags[gi])
            );

            assign w_occ[gi] = (CW'(gi) < r_count);
            assign w_ge[gi]  = w_occ[gi] && w_flags[gi].ge;
            assign w_eq[gi]  = w_flags[gi].eq;
            assign w_idm[gi] = w_occ[gi] && w_flags[gi].idm;

            always_comb begin
                w_ctl[gi].load = spt_pkg::LD_HOLD;
                w_ctl[gi].mk   = w_mk[gi];
                if (r_state == S_EXEC) begin
                    case (r_op)
                        spt_pkg::OP_INSERT: begin
                            if (w_ins_ok && w_t[gi]) begin
                                w_ctl[gi].load = w_s_pv[gi] ? spt_pkg::LD_LEFT : spt_pkg::LD_NEW;
                                w_ctl[gi].mk   = w_s_pv[gi] ? w_mk_pv[gi] : !w_cv;
                            end
                        end
                        spt_pkg::OP_REMOVE_ID, spt_pkg::OP_REMOVE_LOW: begin
                            if (w_rm_ok && w_rm_after[gi]) begin
                                w_ctl[gi].load = spt_pkg::LD_RIGHT;
                                w_ctl[gi].mk   = w_mk_nx[gi]
                                               || (w_pick[gi] && w_mk_rem && w_occ_nx[gi]);
                            end else if (w_rm_ok) begin
                                // removed last entry held the cursor: step back
                                w_ctl[gi].mk = w_mk[gi]
                                             || (w_pick_nx[gi] && w_mk_rem && !w_occ_nx2[gi]);
                            end
                        end
                        spt_pkg::OP_NEXT: begin
                            w_ctl[gi].mk = (w_mk_pv[gi] && w_occ[gi])
                                         || (w_mk[gi] && !w_occ_nx[gi]);
                        end
                        spt_pkg::OP_PREV: begin
                            w_ctl[gi].mk = w_mk_nx[gi] || ((gi == 0) && w_mk[gi]);
                        end
                        spt_pkg::OP_RESET_CUR: begin
                            w_ctl[gi].mk = (gi == 0) && !w_empty;
                        end
                        default: begin
                            w_ctl[gi].mk = w_mk[gi];
                        end
                    endcase
                end
            end
        end
    endgenerate

    // neighbor views of the row
    assign w_mk_pv   = {w_mk[N-2:0], 1'b0};
    assign w_mk_nx   = {1'b0, w_mk[N-1:1]};
    assign w_occ_nx  = {1'b0, w_occ[N-1:1]};
    assign w_occ_nx2 = {1'b0, w_occ_nx[N-1:1]};
    assign w_occ_pv  = {w_occ[N-2:0], 1'b1};
    assign w_s_pv    = {w_s[N-2:0], 1'b0};
    assign w_pick_nx = {1'b0, w_pick[N-1:1]};

    assign w_empty      = (r_count == '0);
    assign w_full       = (r_count == CW'(N));
    assign w_is_last    = w_occ & ~w_occ_nx;
    assign w_eq_last    = |(w_is_last & w_eq);
    // a key tying the last one but below the front goes to the back
    assign w_exc        = !w_empty && w_eq_last && !w_ge[0];
    assign w_s          = w_ge & {N{!w_exc}};
    assign w_first_free = ~w_occ & w_occ_pv;
    assign w_t          = w_s | w_first_free;
    assign w_any_match  = |w_idm;
    assign w_cv         = |w_mk;
    assign w_end_next   = |(w_mk & ~w_occ_nx);
    assign w_end_prev   = w_mk[0];
    assign w_mk_rem     = |(w_pick & w_mk);

    always_comb begin
        w_seen[0] = 1'b0;
        for (int i = 1; i < N; i++) begin
            w_seen[i] = w_seen[i-1] | w_idm[i-1];
        end
    end
    assign w_first_m = w_idm & ~w_seen;
    assign w_pick    = ((r_op == spt_pkg::OP_REMOVE_ID) || (r_op == spt_pkg::OP_EXISTS))
                     ? w_first_m : w_is_last;

    always_comb begin
        w_rm_after[0] = w_pick[0];
        for (int i = 1; i < N; i++) begin
            w_rm_after[i] = w_rm_after[i-1] | w_pick[i];
        end
    end

    always_comb begin
        w_pick_entry = '0;
        w_cur_entry  = '0;
        for (int i = 0; i < N; i++) begin
            w_pick_entry = w_pick_entry | (w_entry[i] & {$bits(spt_pkg::t_entry){w_pick[i]}});
            w_cur_entry  = w_cur_entry | (w_entry[i] & {$bits(spt_pkg::t_entry){w_mk[i]}});
        end
    end

    assign w_ins_ok = (r_op == spt_pkg::OP_INSERT) && !w_full;
    assign w_rm_ok  = ((r_op == spt_pkg::OP_REMOVE_ID) && w_any_match)
                   || ((r_op == spt_pkg::OP_REMOVE_LOW) && !w_empty);

    // result of the compare/shift pass
    always_comb begin
        n_status  = spt_pkg::ST_NONE;
        n_found   = 1'b0;
        n_use_cur = 1'b0;
        n_rentry  = '0;
        case (r_op)
            spt_pkg::OP_INSERT: begin
                n_status = w_full ? spt_pkg::ST_FULL : spt_pkg::ST_OK;
            end
            spt_pkg::OP_REMOVE_ID, spt_pkg::OP_REMOVE_LOW: begin
                if (w_rm_ok) begin
                    n_status = spt_pkg::ST_OK;
                    n_rentry = w_pick_entry;
                end
            end
            spt_pkg::OP_NEXT: begin
                if (w_cv) begin
                    n_status  = w_end_next ? spt_pkg::ST_END : spt_pkg::ST_OK;
                    n_use_cur = 1'b1;
                end
            end
            spt_pkg::OP_PREV: begin
                if (w_cv) begin
                    n_status  = w_end_prev ? spt_pkg::ST_END : spt_pkg::ST_OK;
                    n_use_cur = 1'b1;
                end
            end
            spt_pkg::OP_CURRENT: begin
                if (w_cv) begin
                    n_status  = spt_pkg::ST_OK;
                    n_use_cur = 1'b1;
                end
            end
            spt_pkg::OP_RESET_CUR: begin
                if (!w_empty) begin
                    n_status  = spt_pkg::ST_OK;
                    n_use_cur = 1'b1;
                end
            end
            default: begin
                if (w_any_match) begin
                    n_status = spt_pkg::ST_OK;
                    n_found  = 1'b1;
                    n_rentry = w_pick_entry;
                end
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (r_state == S_EXEC) begin
            if (w_ins_ok) begin
                n_count = r_count + CW'(1);
            end else if (w_rm_ok) begin
                n_count = r_count - CW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = in_accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // cursor entry is read after the pass has moved the marker
    always_comb begin
        spt_pkg::t_entry res;
        res        = r_use_cur ? w_cur_entry : r_rentry;
        n_out_data = '0;
        n_out_data[OutFw-1:0] = {r_found, r_count, res.key, res.id, r_status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op      <= spt_pkg::t_op'(s_axis_tdata[spt_pkg::OpW-1:0]);
            r_new.id  <= s_axis_tdata[spt_pkg::OpW +: spt_pkg::IdW];
            r_new.key <= s_axis_tdata[spt_pkg::OpW + spt_pkg::IdW +: spt_pkg::KeyW];
        end
        if (r_state == S_EXEC) begin
            r_status  <= n_status;
            r_found   <= n_found;
            r_use_cur <= n_use_cur;
            r_rentry  <= n_rentry;
        end
        if ((r_state == S_EMIT) && out_free) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`include "sorted_priority_table_with_cursor_macros.svh"

    `SPT_ASSERT_NOW(a_cursor_single, 1'b1, $onehot0(w_mk), "more than one cursor marker")
    `SPT_ASSERT_NOW(a_cursor_iff_filled, 1'b1, (w_cv == !w_empty), "cursor and fill disagree")
    `SPT_ASSERT_NOW(a_cursor_occupied, 1'b1, ((w_mk & ~w_occ) == '0), "cursor on empty slot")
    `SPT_ASSERT_NEXT(a_exec_to_emit, (r_state == S_EXEC), (r_state == S_EMIT), "pass not reported")

endmodule
